### design/rebd_pkg.sv
// Shared types and constants for the rotary encoder / push-button debouncer.
// No dependencies; imported by every module of the block.
package rebd_pkg;

    // Debounce depth: number of samples that must agree before a level counts
    localparam int DEBOUNCE_SAMPLES = 8;
    localparam int SLOT_W           = $clog2(DEBOUNCE_SAMPLES);

    // Field widths
    localparam int TICK_W = 32;
    localparam int THR_W  = 16;

    // Stream payload widths (byte padded)
    localparam int IN_FIELDS_W  = 3 + TICK_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 4;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Click threshold after reset, in ticks
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(5000);

    typedef enum logic [1:0] {
        BTN_NONE   = 2'd0,
        BTN_CLICK  = 2'd1,
        BTN_ESCAPE = 2'd2
    } t_btn_event;

    typedef enum logic [1:0] {
        TURN_NONE  = 2'd0,
        TURN_LEFT  = 2'd1,
        TURN_RIGHT = 2'd2
    } t_turn_event;

    // Debounce status of one pin after the current sample is written
    typedef struct packed {
        logic stable;   // all history samples agree
        logic level;    // the agreed level (valid when stable)
    } t_hist_stat;

endpackage

### design/rebd_hist.sv
// Sample history for one pin: writes the new sample at the rotating slot and
// reports whether all samples agree. Depends on rebd_pkg.
module rebd_hist (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic [rebd_pkg::SLOT_W-1:0] i_slot,
    input  logic                       i_level,
    output rebd_pkg::t_hist_stat       o_stat
);
    import rebd_pkg::*;

    logic [DEBOUNCE_SAMPLES-1:0] r_hist;
    logic [DEBOUNCE_SAMPLES-1:0] n_hist;

    // Overwrite the sample at the current slot
    always_comb begin
        n_hist         = r_hist;
        n_hist[i_slot] = i_level;
    end

    // Status is taken from the history including this sample
    assign o_stat.stable = (n_hist == '0) || (n_hist == '1);
    assign o_stat.level  = n_hist[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '1;
        end else if (i_adv) begin
            r_hist <= n_hist;
        end
    end

endmodule

### design/rebd_press.sv
// Button press tracking: stable level, press timestamp and arm flag; decides
// click versus long-press escape. Depends on rebd_pkg.
module rebd_press (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  rebd_pkg::t_hist_stat        i_stat,
    input  logic [rebd_pkg::TICK_W-1:0] i_now,
    input  logic [rebd_pkg::THR_W-1:0]  i_threshold,
    output rebd_pkg::t_btn_event        o_event
);
    import rebd_pkg::*;

    logic              r_stable;
    logic              r_armed;
    logic [TICK_W-1:0] r_press_time;

    logic              n_stable;
    logic              n_armed;
    logic              n_take_time;
    logic [TICK_W-1:0] elapsed;
    logic [TICK_W-1:0] thr_ext;

    // Elapsed ticks since the press, modulo 2^32
    assign elapsed = i_now - r_press_time;
    assign thr_ext = TICK_W'(i_threshold);

    // Press / release / hold decisions
    always_comb begin
        n_stable    = r_stable;
        n_armed     = r_armed;
        n_take_time = 1'b0;
        o_event     = BTN_NONE;
        if (i_stat.stable) begin
            if (i_stat.level != r_stable) begin
                n_stable = i_stat.level;
                if (!i_stat.level) begin
                    n_take_time = 1'b1;
                    n_armed     = 1'b1;
                end else if (r_armed && (elapsed <= thr_ext)) begin
                    o_event = BTN_CLICK;
                end
            end else if (!i_stat.level && r_armed && (elapsed >= thr_ext)) begin
                o_event = BTN_ESCAPE;
                n_armed = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b1;
            r_armed  <= 1'b1;
        end else if (i_adv) begin
            r_stable <= n_stable;
            r_armed  <= n_armed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_time <= '0;
        end else if (i_adv && n_take_time) begin
            r_press_time <= i_now;
        end
    end

`ifndef SYNTH
    // Escape disarms, so no click can follow the same press
    a_escape_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_event == BTN_ESCAPE) |=> !r_armed)
        else $error("escape reported but press still armed");

    // A click is only reported on a stable release
    a_click_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_event == BTN_CLICK) |=> r_stable)
        else $error("click reported without stable release");

    // A new press takes the timestamp of that tick
    a_press_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && n_take_time) |=> (r_press_time == $past(i_now)))
        else $error("press time not captured");
`endif

endmodule

### design/rotary_encoder_button_debouncer.sv
// Rotary encoder and push-button debouncer with long-press escape. Takes one
// pin sample per request and returns one event request (button event, turn
// event) for each. Throughput is one request per clock while the output is not
// stalled; each request passes through the input register and the result
// register, with all debounce and timing logic in the single stage between.
// The click threshold is written over the configuration channel, which is
// always ready; write it only while no request is in flight.
// Depends on rebd_pkg, rebd_hist and rebd_press.
module rotary_encoder_button_debouncer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream: [0] button_level, [1] chan_a_level, [2] chan_b_level,
    // [34:3] now_tick, rest zero
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [rebd_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // Output stream: [1:0] button_event, [3:2] turn_event, rest zero
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [rebd_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // Configuration: click_threshold
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rebd_pkg::THR_W-1:0]       i_cfg_data
);
    import rebd_pkg::*;

    // Input register
    logic              r_in_valid;
    logic              r_in_btn;
    logic              r_in_ca;
    logic              r_in_cb;
    logic [TICK_W-1:0] r_in_now;

    // Result register
    logic              r_out_valid;
    t_btn_event        r_out_bev;
    t_turn_event       r_out_tev;

    logic [THR_W-1:0]  r_threshold;
    logic [SLOT_W-1:0] r_slot;
    logic              r_ca_stable;

    logic              adv;
    t_hist_stat        btn_stat;
    t_hist_stat        ca_stat;
    t_btn_event        n_bev;
    t_turn_event       n_tev;

    // Handshake: stage moves when the result register is free or drains
    assign adv         = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_btn <= i_s_tdata[0];
            r_in_ca  <= i_s_tdata[1];
            r_in_cb  <= i_s_tdata[2];
            r_in_now <= i_s_tdata[3 +: TICK_W];
        end
    end

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RESET;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    // Rotating history slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (adv) begin
            if (r_slot == SLOT_W'(DEBOUNCE_SAMPLES - 1)) begin
                r_slot <= '0;
            end else begin
                r_slot <= r_slot + SLOT_W'(1);
            end
        end
    end

    rebd_hist u_btn_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_slot  (r_slot),
        .i_level (r_in_btn),
        .o_stat  (btn_stat)
    );

    rebd_hist u_ca_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_slot  (r_slot),
        .i_level (r_in_ca),
        .o_stat  (ca_stat)
    );

    rebd_press u_press (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_stat      (btn_stat),
        .i_now       (r_in_now),
        .i_threshold (r_threshold),
        .o_event     (n_bev)
    );

    // Turn direction on a stable channel A edge: B equal to new A means left
    always_comb begin
        n_tev = TURN_NONE;
        if (ca_stat.stable && (ca_stat.level != r_ca_stable)) begin
            n_tev = (r_in_cb == ca_stat.level) ? TURN_LEFT : TURN_RIGHT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ca_stable <= 1'b1;
        end else if (adv && ca_stat.stable) begin
            r_ca_stable <= ca_stat.level;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_bev <= n_bev;
            r_out_tev <= n_tev;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), r_out_tev, r_out_bev};

endmodule

### verif/tb_rotary_encoder_button_debouncer.sv
`timescale 1ns / 100ps
// Self-checking testbench for rotary_encoder_button_debouncer: streams pin-sample
// requests, predicts the click / escape / turn events of every sample and checks each
// result request. Depends on rebd_pkg and the design top level.
module tb_rotary_encoder_button_debouncer;
    import rebd_pkg::*;

    typedef struct {
        logic              button;
        logic              chan_a;
        logic              chan_b;
        logic [TICK_W-1:0] now;
    } t_pin_sample;

    typedef struct {
        t_btn_event  btn;
        t_turn_event turn;
    } t_event_pair;

    // DUT ports
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [THR_W-1:0]       i_cfg_data  = '0;

    // Stimulus and scoreboard
    t_pin_sample pending_samples_q[$];
    t_event_pair expected_events_q[$];
    int          samples_issued = 0;
    int          results_seen   = 0;
    int          mismatch_count = 0;
    logic        s_accepted     = 1'b0;
    bit          calm           = 1'b0;
    int          hold_requests  = 0;

    // Generator state
    logic [TICK_W-1:0] tick_now;
    logic              btn_target;
    logic              a_target;

    // Predicted debouncer state
    logic [SLOT_W-1:0]           pred_slot;
    logic [DEBOUNCE_SAMPLES-1:0] pred_btn_hist;
    logic [DEBOUNCE_SAMPLES-1:0] pred_a_hist;
    logic                        pred_btn_stable;
    logic                        pred_a_stable;
    logic                        pred_armed;
    logic [TICK_W-1:0]           pred_press_time;
    logic [THR_W-1:0]            pred_threshold;

    rotary_encoder_button_debouncer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // One line per mismatch, and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // One sampling tick of the debouncer: updates the predicted state
    task automatic predict_events(input t_pin_sample s, output t_event_pair ev);
        logic [DEBOUNCE_SAMPLES-1:0] slot_bit;
        logic [TICK_W-1:0]           elapsed;
        logic                        lvl;
        ev.btn   = BTN_NONE;
        ev.turn  = TURN_NONE;
        slot_bit = DEBOUNCE_SAMPLES'(1) << pred_slot;
        pred_slot = (pred_slot == SLOT_W'(DEBOUNCE_SAMPLES - 1)) ? '0 : pred_slot + 1'b1;

        // button: press timing, click on early release, escape on long hold
        pred_btn_hist = s.button ? (pred_btn_hist | slot_bit) : (pred_btn_hist & ~slot_bit);
        if (pred_btn_hist == '0 || pred_btn_hist == '1) begin
            lvl     = (pred_btn_hist == '1);
            elapsed = s.now - pred_press_time;
            if (lvl != pred_btn_stable) begin
                if (!lvl) begin
                    pred_press_time = s.now;
                    pred_armed      = 1'b1;
                end else if (pred_armed && elapsed <= TICK_W'(pred_threshold)) begin
                    ev.btn = BTN_CLICK;
                end
                pred_btn_stable = lvl;
            end else if (!lvl && pred_armed && elapsed >= TICK_W'(pred_threshold)) begin
                ev.btn     = BTN_ESCAPE;
                pred_armed = 1'b0;
            end
        end

        // channel A edge, direction from channel B
        pred_a_hist = s.chan_a ? (pred_a_hist | slot_bit) : (pred_a_hist & ~slot_bit);
        if (pred_a_hist == '0 || pred_a_hist == '1) begin
            lvl = (pred_a_hist == '1);
            if (lvl != pred_a_stable)
                ev.turn = (s.chan_b == lvl) ? TURN_LEFT : TURN_RIGHT;
            pred_a_stable = lvl;
        end
    endtask

    // Monitor: predicts on each accepted input, checks each accepted result
    always @(posedge i_clk) begin : monitor
        t_pin_sample s;
        t_event_pair ev;
        s_accepted <= i_s_tvalid && o_s_tready;
        if (!i_rst_n) begin
            pred_slot       = '0;
            pred_btn_hist   = '1;
            pred_a_hist     = '1;
            pred_btn_stable = 1'b1;
            pred_a_stable   = 1'b1;
            pred_armed      = 1'b1;
            pred_press_time = '0;
            pred_threshold  = THR_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                pred_threshold = i_cfg_data;
            if (i_s_tvalid && o_s_tready) begin
                s.button = i_s_tdata[0];
                s.chan_a = i_s_tdata[1];
                s.chan_b = i_s_tdata[2];
                s.now    = i_s_tdata[3 +: TICK_W];
                predict_events(s, ev);
                expected_events_q.push_back(ev);
            end
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (expected_events_q.size() == 0) begin
                    report_mismatch("result with no request pending", int'(o_m_tdata), 0);
                end else begin
                    ev = expected_events_q.pop_front();
                    if (o_m_tdata[1:0] != ev.btn)
                        report_mismatch("button_event", int'(o_m_tdata[1:0]), int'(ev.btn));
                    if (o_m_tdata[3:2] != ev.turn)
                        report_mismatch("turn_event", int'(o_m_tdata[3:2]), int'(ev.turn));
                end
            end
        end
    end

    // Sender: pops pending samples, idles in random bursts
    always @(negedge i_clk) begin : sender
        t_pin_sample s;
        int          gap;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            gap = 0;
        end else if (!i_s_tvalid || s_accepted) begin
            if (gap > 0) begin
                gap--;
                i_s_tvalid <= 1'b0;
            end else if (pending_samples_q.size() > 0) begin
                s = pending_samples_q.pop_front();
                i_s_tdata  <= IN_TDATA_W'({s.now, s.chan_b, s.chan_a, s.button});
                i_s_tvalid <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    gap = $urandom_range(1, 19);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request
    always @(negedge i_clk) begin : receiver
        int stall;
        int hold_served;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall       = 0;
            hold_served = 0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            stall       = 250;
            i_m_tready <= 1'b0;
        end else if (stall > 0) begin
            stall--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0)
                stall = $urandom_range(1, 19);
        end
    end

    task automatic queue_sample(input logic b, input logic a, input logic cb,
                                input logic [TICK_W-1:0] now);
        t_pin_sample s;
        s.button = b;
        s.chan_a = a;
        s.chan_b = cb;
        s.now    = now;
        pending_samples_q.push_back(s);
        samples_issued++;
    endtask

    // Every request has one result; wait for all, then keep watching for strays
    task automatic wait_drained();
        while (results_seen < samples_issued)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Held levels for 8..14 samples, possibly bouncing at the start of the run
    task automatic queue_episode(input int unsigned step_max);
        int unsigned n;
        int unsigned bounce;
        logic        b;
        logic        a;
        logic        cb;
        n      = $urandom_range(8, 14);
        bounce = $urandom_range(0, 3);
        cb     = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1))
            btn_target = ~btn_target;
        if ($urandom_range(0, 1))
            a_target = ~a_target;
        for (int i = 0; i < n; i++) begin
            b = btn_target;
            a = a_target;
            if (i < bounce) begin
                b ^= 1'($urandom_range(0, 1));
                a ^= 1'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 3) == 0)
                cb = ~cb;
            tick_now += $urandom_range(0, step_max);
            queue_sample(b, a, cb, tick_now);
        end
    endtask

    // Random pin chatter, sometimes with a jump of the timestamp
    task automatic queue_noise();
        int unsigned n;
        n = $urandom_range(1, 6);
        if ($urandom_range(0, 2) == 0)
            tick_now = $urandom();
        for (int i = 0; i < n; i++) begin
            tick_now += $urandom_range(0, 3);
            queue_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), tick_now);
        end
    endtask

    task automatic run_random_phase(input bit write_cfg, input logic [THR_W-1:0] thr,
                                    input int items, input bit long_hold);
        int start;
        int unsigned thr_i;
        if (write_cfg)
            write_threshold(thr);
        thr_i = 32'(thr);
        start = samples_issued;
        while (samples_issued - start < items) begin
            if ($urandom_range(0, 7) == 0)
                queue_noise();
            else
                queue_episode($urandom_range(thr_i / 16, thr_i / 3) + 1);
        end
        if (long_hold)
            hold_requests++;
        wait_drained();
    endtask

    initial begin : stimulus
        logic [TICK_W-1:0] t;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Press across the timestamp wrap with a left turn, then release exactly
        // at the threshold together with a right turn
        write_threshold(THR_W'(10));
        t = 32'hFFFF_FFF0;
        for (int i = 0; i < 8; i++)
            queue_sample(1'b0, 1'b0, 1'b0, t + i);
        t = t + 7;
        for (int i = 1; i < 8; i++)
            queue_sample(1'b1, 1'b1, 1'b0, t + i);
        queue_sample(1'b1, 1'b1, 1'b0, t + 10);
        wait_drained();

        // Zero threshold: escape on the tick after the stable press
        write_threshold('0);
        for (int i = 0; i < 9; i++)
            queue_sample(1'b0, 1'b1, 1'b1, 32'd100 + i);
        wait_drained();

        // Random part; starts held pressed so the first release follows an escape
        tick_now   = 32'd200;
        btn_target = 1'b0;
        a_target   = 1'b1;
        run_random_phase(1'b0, '0, 250, 1'b0);
        run_random_phase(1'b1, THR_W'(1), 250, 1'b0);
        run_random_phase(1'b1, '1, 250, 1'b1);
        run_random_phase(1'b1, THR_RESET, 250, 1'b0);
        run_random_phase(1'b1, THR_W'($urandom_range(2, 400)), 250, 1'b0);
        run_random_phase(1'b1, THR_W'($urandom()), 250, 1'b0);
        calm = 1'b1;
        run_random_phase(1'b1, THR_W'($urandom_range(3, 60)), 250, 1'b0);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
